// File: rtl/tpid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the thermal PID difference controller.
// No dependencies; imported by every other file of the block.
package tpid_pkg;

    localparam int TEMP_W  = 24;
    localparam int ERR_W   = 25;
    localparam int COEF_W  = 32;
    localparam int DRIVE_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W   = 67;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ERR0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ERR1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ERR2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_OUT1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_OUT2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP = 3'd5;

    // Reset values of the registers
    localparam logic signed [COEF_W-1:0] RST_COEF_ERR0   = 32'sd50000;
    localparam logic signed [COEF_W-1:0] RST_COEF_ERR1   = -32'sd49722;
    localparam logic signed [COEF_W-1:0] RST_COEF_ERR2   = 32'sd0;
    localparam logic signed [COEF_W-1:0] RST_COEF_OUT1   = -32'sd1;
    localparam logic signed [COEF_W-1:0] RST_COEF_OUT2   = 32'sd0;
    localparam logic signed [TEMP_W-1:0] RST_TARGET_TEMP = 24'sd85000;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_err0;
        logic signed [COEF_W-1:0] coef_err1;
        logic signed [COEF_W-1:0] coef_err2;
        logic signed [COEF_W-1:0] coef_out1;
        logic signed [COEF_W-1:0] coef_out2;
        logic signed [TEMP_W-1:0] target_temp;
    } t_coefs;

endpackage

// File: rtl/tpid_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: gains and temperature setpoint.
// Depends on tpid_pkg.
module tpid_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tpid_pkg::COEF_W-1:0]        i_cfg_wdata,
    output tpid_pkg::t_coefs                   o_coefs
);
    import tpid_pkg::*;

    t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.coef_err0   <= RST_COEF_ERR0;
            r_coefs.coef_err1   <= RST_COEF_ERR1;
            r_coefs.coef_err2   <= RST_COEF_ERR2;
            r_coefs.coef_out1   <= RST_COEF_OUT1;
            r_coefs.coef_out2   <= RST_COEF_OUT2;
            r_coefs.target_temp <= RST_TARGET_TEMP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COEF_ERR0:   r_coefs.coef_err0   <= i_cfg_wdata;
                CFG_COEF_ERR1:   r_coefs.coef_err1   <= i_cfg_wdata;
                CFG_COEF_ERR2:   r_coefs.coef_err2   <= i_cfg_wdata;
                CFG_COEF_OUT1:   r_coefs.coef_out1   <= i_cfg_wdata;
                CFG_COEF_OUT2:   r_coefs.coef_out2   <= i_cfg_wdata;
                CFG_TARGET_TEMP: r_coefs.target_temp <= i_cfg_wdata[TEMP_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

// File: rtl/tpid_datapath.sv
`timescale 1ns / 1ps
// Difference-equation datapath: error, five full-width products, 67-bit sum,
// saturation to 32 bits, and the error/output history. Depends on tpid_pkg.
module tpid_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_advance,
    input  logic signed [tpid_pkg::TEMP_W-1:0]   i_temp,
    input  tpid_pkg::t_coefs                     i_coefs,
    output logic signed [tpid_pkg::DRIVE_W-1:0]  o_drive,
    output logic                                 o_sat
);
    import tpid_pkg::*;

    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [ERR_W-1:0]   r_prev_err_2;
    logic signed [DRIVE_W-1:0] r_prev_out;
    logic signed [DRIVE_W-1:0] r_prev_out_2;

    logic signed [ERR_W-1:0]   n_err;
    logic signed [63:0]        w_p_out1;
    logic signed [63:0]        w_p_out2;
    logic signed [56:0]        w_p_err0;
    logic signed [56:0]        w_p_err1;
    logic signed [56:0]        w_p_err2;
    logic signed [ACC_W-1:0]   w_acc;
    logic                      w_in_range;

    assign n_err = $signed({i_coefs.target_temp[TEMP_W-1], i_coefs.target_temp})
                 - $signed({i_temp[TEMP_W-1], i_temp});

    assign w_p_out1 = i_coefs.coef_out1 * r_prev_out;
    assign w_p_out2 = i_coefs.coef_out2 * r_prev_out_2;
    assign w_p_err0 = i_coefs.coef_err0 * n_err;
    assign w_p_err1 = i_coefs.coef_err1 * r_prev_err;
    assign w_p_err2 = i_coefs.coef_err2 * r_prev_err_2;

    assign w_acc = $signed({{10{w_p_err0[56]}}, w_p_err0})
                 + $signed({{10{w_p_err1[56]}}, w_p_err1})
                 + $signed({{10{w_p_err2[56]}}, w_p_err2})
                 - $signed({{3{w_p_out1[63]}}, w_p_out1})
                 - $signed({{3{w_p_out2[63]}}, w_p_out2});

    // fits in 32 bits when everything above bit 30 is a copy of the sign
    assign w_in_range = (w_acc[ACC_W-1:DRIVE_W-1] == {(ACC_W-DRIVE_W+1){w_acc[ACC_W-1]}});

    always_comb begin
        if (w_in_range) begin
            o_drive = w_acc[DRIVE_W-1:0];
            o_sat   = 1'b0;
        end else begin
            o_drive = w_acc[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX;
            o_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err   <= '0;
            r_prev_err_2 <= '0;
            r_prev_out   <= '0;
            r_prev_out_2 <= '0;
        end else if (i_advance) begin
            r_prev_err_2 <= r_prev_err;
            r_prev_err   <= n_err;
            r_prev_out_2 <= r_prev_out;
            r_prev_out   <= o_drive;
        end
    end

`ifndef SYNTHESIS
    a_out_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> (r_prev_out_2 == $past(r_prev_out)) && (r_prev_out == $past(o_drive)))
        else $error("output history did not shift");

    a_err_hist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_prev_err) && $stable(r_prev_err_2))
        else $error("error history changed without a sample");
`endif

endmodule

// File: rtl/thermal_pid_difference_controller.sv
`timescale 1ns / 1ps
// A sample accepted on the input stream is held in the input register; its result is
// computed from there and registered in the result register, from which it is offered;
// throughput one sample per cycle while the result side is not stalled, set by the single
// registered pass through the five multipliers and the 67-bit sum.
// A result waits in the output register; an empty input register still takes a new sample.
// Synchronous active-low reset restores the default gains/setpoint and clears history.
module thermal_pid_difference_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tpid_pkg::TEMP_W-1:0]         s_axis_tdata,   // [23:0] measured_temp
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tpid_pkg::DRIVE_W-1:0]        m_axis_tdata,   // [31:0] drive_value
    output logic                                m_axis_tuser,   // [0] saturated
    input  logic                                i_cfg_we,
    input  logic [tpid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpid_pkg::COEF_W-1:0]         i_cfg_wdata
);
    import tpid_pkg::*;

    t_coefs                    w_coefs;
    logic                      r_s1_valid;
    logic signed [TEMP_W-1:0]  r_s1_temp;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_out_drive;
    logic                      r_out_sat;
    logic signed [DRIVE_W-1:0] w_drive;
    logic                      w_sat;
    logic                      w_advance;
    logic                      w_in_xfer;

    tpid_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coefs     (w_coefs)
    );

    tpid_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_temp    (r_s1_temp),
        .i_coefs   (w_coefs),
        .o_drive   (w_drive),
        .o_sat     (w_sat)
    );

    // sample in stage 1 moves to the result register when that slot frees up
    assign w_advance     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_advance;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_temp <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out_drive <= w_drive;
            r_out_sat   <= w_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_drive;
    assign m_axis_tuser  = r_out_sat;

`ifndef SYNTHESIS
    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> (r_out_drive == DRIVE_MAX || r_out_drive == DRIVE_MIN))
        else $error("saturation flag set but output not at a rail");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_s1_valid)
        else $error("accepted sample lost before compute");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !m_axis_tready) |=> r_s1_valid && $stable(r_s1_temp))
        else $error("pending sample dropped during output stall");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for thermal_pid_difference_controller: directed and random samples,
// random idling on both stream sides, gain/setpoint changes between phases.
// Depends on rtl/tpid_pkg.sv and rtl/thermal_pid_difference_controller.sv.
module testbench;
    import tpid_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int MAX_GAP        = 16;
    localparam int RX_HOLD_AT     = 200;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 104;
    localparam int MAX_REPORTS    = 10;

    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic [DRIVE_W-1:0] drive;
        logic               sat;
    } t_drive_result;

    // Predicts drive values from the sample stream and checks them in order.
    class pid_scoreboard;
        logic signed [COEF_W-1:0]  gain_e0, gain_e1, gain_e2, gain_y1, gain_y2;
        logic signed [TEMP_W-1:0]  target;
        logic signed [ERR_W-1:0]   err_d1, err_d2;
        logic signed [DRIVE_W-1:0] drive_d1, drive_d2;
        t_drive_result             expected_drives[$];
        int                        faults;

        function new();
            gain_e0  = RST_COEF_ERR0;
            gain_e1  = RST_COEF_ERR1;
            gain_e2  = RST_COEF_ERR2;
            gain_y1  = RST_COEF_OUT1;
            gain_y2  = RST_COEF_OUT2;
            target   = RST_TARGET_TEMP;
            err_d1   = '0;
            err_d2   = '0;
            drive_d1 = '0;
            drive_d2 = '0;
            faults   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
            case (idx)
                CFG_COEF_ERR0:   gain_e0 = value;
                CFG_COEF_ERR1:   gain_e1 = value;
                CFG_COEF_ERR2:   gain_e2 = value;
                CFG_COEF_OUT1:   gain_y1 = value;
                CFG_COEF_OUT2:   gain_y2 = value;
                CFG_TARGET_TEMP: target  = value[TEMP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [TEMP_W-1:0] raw);
            logic signed [ERR_W-1:0] t_ext, s_ext, err;
            logic signed [ACC_W-1:0] x0, x1, x2, y1, y2, k0, k1, k2, k3, k4, acc;
            t_drive_result           res;
            t_ext = target;
            s_ext = $signed(raw);
            err   = t_ext - s_ext;
            x0 = err;      x1 = err_d1;   x2 = err_d2;
            y1 = drive_d1; y2 = drive_d2;
            k0 = gain_e0;  k1 = gain_e1;  k2 = gain_e2;
            k3 = gain_y1;  k4 = gain_y2;
            // every product fits well inside the 67-bit sum
            acc = k0 * x0 + k1 * x1 + k2 * x2 - k3 * y1 - k4 * y2;
            if (acc > DRIVE_MAX) begin
                res.drive = DRIVE_MAX;
                res.sat   = 1'b1;
            end else if (acc < DRIVE_MIN) begin
                res.drive = DRIVE_MIN;
                res.sat   = 1'b1;
            end else begin
                res.drive = acc[DRIVE_W-1:0];
                res.sat   = 1'b0;
            end
            err_d2   = err_d1;
            err_d1   = err;
            drive_d2 = drive_d1;
            drive_d1 = res.drive;
            expected_drives.push_back(res);
        endfunction

        function void check_result(logic [DRIVE_W-1:0] drive, logic sat);
            t_drive_result want;
            if (expected_drives.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected result: drive %0d sat %0b", $signed(drive), sat);
                return;
            end
            want = expected_drives.pop_front();
            if (drive !== want.drive || sat !== want.sat) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("mismatch at %0t: drive exp %0d got %0d, sat exp %0b got %0b",
                             $realtime, $signed(want.drive), $signed(drive), want.sat, sat);
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TEMP_W-1:0]    s_axis_tdata = '0;       // [23:0] measured_temp
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DRIVE_W-1:0]   m_axis_tdata;            // [31:0] drive_value
    logic                 m_axis_tuser;            // [0] saturated
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0]    i_cfg_wdata = '0;

    pid_scoreboard ledger = new();
    bit            no_idle = 1'b0;
    int            idle_cycles = 0;

    thermal_pid_difference_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                ledger.check_result(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                ledger.note_sample(s_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off to back up the input.
    initial begin : result_sink
        int stall;
        int n_taken;
        n_taken = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            n_taken++;
            if (n_taken == RX_HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic [TEMP_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        ledger.write_reg(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_gain(input bit feedback);
        case ($urandom_range(0, 3))
            0, 1: begin
                if (feedback)
                    return 32'($urandom_range(0, 4)) - 32'd2;
                return 32'($urandom_range(0, 131071)) - 32'd65536;
            end
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    3: return 32'd1;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [TEMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return ledger.target + 24'($urandom_range(0, 2000)) - 24'd1000;
        if (r < 17)
            return 24'($urandom);
        case (r)
            17: return 24'h7F_FFFF;
            18: return 24'h80_0000;
            default: return ($urandom_range(0, 1) != 0) ? 24'h00_0000 : 24'hFF_FFFF;
        endcase
    endfunction

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default gains: zero error, both saturation directions, bit patterns
        send_sample(24'sd85000);
        send_sample(24'sd84999);
        send_sample(24'sd85001);
        send_sample(24'h80_0000);
        send_sample(24'h7F_FFFF);
        send_sample(24'h00_0000);
        send_sample(24'hFF_FFFF);
        send_sample(24'h55_5555);
        send_sample(24'hAA_AAAA);
        wait_drained();

        // extreme gains drive the sum past 64 bits; target carries junk above bit 23
        write_reg(CFG_COEF_ERR0, 32'h7FFF_FFFF);
        write_reg(CFG_COEF_ERR1, 32'h8000_0000);
        write_reg(CFG_COEF_ERR2, 32'h7FFF_FFFF);
        write_reg(CFG_COEF_OUT1, 32'h8000_0000);
        write_reg(CFG_COEF_OUT2, 32'h8000_0000);
        write_reg(CFG_TARGET_TEMP, 32'hA580_0000);
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
        send_sample(24'h7F_FFFF);
        send_sample(24'h7F_FFFF);
        send_sample(24'h80_0000);
        send_sample(24'h7F_FFFF);
        send_sample(24'h80_0000);
        send_sample(24'h00_0000);
        wait_drained();

        // unit gain, widest error without clipping
        write_reg(CFG_COEF_ERR0, 32'd1);
        write_reg(CFG_COEF_ERR1, '0);
        write_reg(CFG_COEF_ERR2, '0);
        write_reg(CFG_COEF_OUT1, '0);
        write_reg(CFG_COEF_OUT2, '0);
        write_reg(CFG_TARGET_TEMP, 32'h007F_FFFF);
        send_sample(24'h80_0000);
        send_sample(24'h7F_FFFF);
        send_sample(24'h00_0000);
        send_sample(24'hFF_FFFF);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_ERR0, pick_gain(1'b0));
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_ERR1, pick_gain(1'b0));
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_ERR2, pick_gain(1'b0));
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_OUT1, pick_gain(1'b1));
            if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_OUT2, pick_gain(1'b1));
            if ($urandom_range(0, 1) != 0)
                write_reg(CFG_TARGET_TEMP, ($urandom_range(0, 1) != 0) ?
                          32'($urandom) : 32'($urandom_range(20000, 110000)));
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 26 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_sample(pick_sample());
            end
        end
        wait_drained();

        if (ledger.faults == 0 && ledger.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/tpid_pkg.sv
rtl/tpid_cfg_regs.sv
rtl/tpid_datapath.sv
rtl/thermal_pid_difference_controller.sv
tb/testbench.sv
